FILE: rtl/core/i2cm_pkg.sv
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned BIT_CNT_W       = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QUEUE_PTR_W     = 1;
  localparam int unsigned QUEUE_CNT_W     = 2;

  localparam logic [CFG_W-1:0]     HALF_PERIOD_RST = 16'd250;
  localparam logic [CFG_W-1:0]     ACK_TIMEOUT_RST = 16'd0;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD,
    CFG_ACK_TIMEOUT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_STOP,
    MODE_WRITE,
    MODE_READ
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_WR_HIGH,
    PH_WR_LOW,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_ACK_LOW,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_NACK_HIGH
  } phase_e;

  typedef struct packed {
    logic              cmd_valid;
    logic [1:0]        mode;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_in;
  } i2cm_in_t;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] tx_byte;
    logic              sda_in;
  } i2cm_item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              ready_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;
  } i2cm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] half_period;
    logic [CFG_W-1:0] ack_timeout;
  } i2cm_cfg_t;

endpackage

FILE: rtl/core/i2cm_chan_if.sv
// valid/ready channel carrying one payload per request
interface i2cm_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/core/i2cm_front.sv
// front end: classifies ticks and queues them for the bit engine
module i2cm_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_chan_if.sink   tick_snk,
  i2cm_chan_if.source q_src
);
  import i2cm_pkg::*;

  i2cm_item_t             entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push, pop;
  i2cm_item_t             item;

  // map the raw command fields onto one operation code
  always_comb begin
    item.tx_byte = tick_snk.payload.tx_byte;
    item.sda_in  = tick_snk.payload.sda_in;
    item.op      = OP_NONE;
    if (tick_snk.payload.cmd_valid) begin
      unique case (mode_e'(tick_snk.payload.mode))
        MODE_START: item.op = OP_START;
        MODE_STOP:  item.op = OP_STOP;
        MODE_WRITE: item.op = OP_WRITE;
        MODE_READ:  item.op = OP_READ;
        default:    item.op = OP_NONE;
      endcase
    end
  end

  assign tick_snk.ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push           = tick_snk.valid && tick_snk.ready;
  assign q_src.valid    = (count_q != '0);
  assign q_src.payload  = entry_q[rd_ptr_q];
  assign pop            = q_src.valid && q_src.ready;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop && count_q == '0 |=> q_src.valid)
    else $error("pushed request not visible at queue head");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/core/i2cm_engine.sv
// back end: bit-level i2c sequencer, one queued tick per step
module i2cm_engine #(
  parameter int unsigned TimerWidth = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cm_pkg::i2cm_cfg_t cfg_i,
  i2cm_chan_if.sink           q_snk,
  i2cm_chan_if.source         res_src
);
  import i2cm_pkg::*;

  phase_e                phase_q, phase_d;
  logic [TimerWidth-1:0] tick_q, tick_d;
  logic [TimerWidth-1:0] ack_cnt_q, ack_cnt_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [BYTE_W-1:0]     shift_q, shift_d;
  logic [BYTE_W-1:0]     rx_hold_q, rx_hold_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic                  ack_flag_q, ack_flag_d;
  logic                  done;
  logic                  out_valid_q, out_valid_d;
  i2cm_out_t             out_q;

  logic [TimerWidth-1:0] hp_lim, tmo_lim, ack_cnt_inc;
  logic                  wait_over, tmo_hit, step, sda_s, in_wait;
  logic [2:0]            wr_idx;
  i2cm_item_t            item;

  assign item        = q_snk.payload;
  assign sda_s       = item.sda_in;
  assign hp_lim      = TimerWidth'(cfg_i.half_period);
  assign tmo_lim     = TimerWidth'(cfg_i.ack_timeout);
  assign wait_over   = (tick_q >= hp_lim);
  assign ack_cnt_inc = (ack_cnt_q == '1) ? ack_cnt_q : ack_cnt_q + 1'b1;
  assign tmo_hit     = (tmo_lim != '0) && (ack_cnt_inc >= tmo_lim);
  assign wr_idx      = 3'd7 - bit_cnt_q[2:0];
  assign in_wait     = (phase_q != PH_IDLE) && (phase_q != PH_ACK_POLL);

  // a step runs whenever a tick is queued and the result register is free or being drained
  assign q_snk.ready = !out_valid_q || res_src.ready;
  assign step        = q_snk.valid && q_snk.ready;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step) begin
      unique case (phase_q)
        PH_IDLE: begin
          unique case (item.op)
            OP_START: phase_d = PH_ST_A;
            OP_STOP:  phase_d = PH_SP_A;
            OP_WRITE: phase_d = PH_WR_HIGH;
            OP_READ:  phase_d = PH_RD_HIGH;
            default:  phase_d = PH_IDLE;
          endcase
        end
        PH_ACK_POLL:  if (!sda_s || tmo_hit) phase_d = PH_ACK_LOW;
        PH_ST_A:      if (wait_over) phase_d = PH_ST_B;
        PH_ST_B:      if (wait_over) phase_d = PH_IDLE;
        PH_SP_A:      if (wait_over) phase_d = PH_SP_B;
        PH_SP_B:      if (wait_over) phase_d = PH_IDLE;
        PH_WR_HIGH:   if (wait_over) phase_d = PH_WR_LOW;
        PH_WR_LOW: begin
          if (wait_over) begin
            phase_d = (bit_cnt_q >= BITS_PER_BYTE) ? PH_ACK_HIGH : PH_WR_HIGH;
          end
        end
        PH_ACK_HIGH:  if (wait_over) phase_d = PH_ACK_POLL;
        PH_ACK_LOW:   if (wait_over) phase_d = PH_IDLE;
        PH_RD_HIGH:   if (wait_over) phase_d = PH_RD_LOW;
        PH_RD_LOW: begin
          if (wait_over) begin
            phase_d = (bit_cnt_q >= BITS_PER_BYTE) ? PH_NACK_HIGH : PH_RD_HIGH;
          end
        end
        PH_NACK_HIGH: if (wait_over) phase_d = PH_IDLE;
        default:      phase_d = PH_IDLE;
      endcase
    end
  end

  // line levels, counters and data
  always_comb begin
    tick_d     = tick_q;
    ack_cnt_d  = ack_cnt_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    rx_hold_d  = rx_hold_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_flag_d = ack_flag_q;
    done       = 1'b0;
    if (step) begin
      // fresh wait on entry, otherwise count up until the wait is over
      if (phase_d != phase_q && phase_d != PH_IDLE && phase_d != PH_ACK_POLL) begin
        tick_d = TimerWidth'(1);
      end else if (in_wait && !wait_over) begin
        tick_d = tick_q + 1'b1;
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (item.op != OP_NONE) begin
            bit_cnt_d = '0;
          end
          unique case (item.op)
            OP_START: begin
              scl_d = 1'b1;
              sda_d = 1'b1;
            end
            OP_STOP: begin
              scl_d = 1'b0;
              sda_d = 1'b0;
            end
            OP_WRITE: begin
              shift_d = item.tx_byte;
              sda_d   = item.tx_byte[BYTE_W-1];
              scl_d   = 1'b1;
            end
            OP_READ: begin
              shift_d = '0;
              sda_d   = 1'b1;
              scl_d   = 1'b1;
            end
            default: ;
          endcase
        end
        PH_ACK_POLL: begin
          if (!sda_s) begin
            ack_flag_d = 1'b1;
            scl_d      = 1'b0;
          end else begin
            ack_cnt_d = ack_cnt_inc;
            if (tmo_hit) begin
              ack_flag_d = 1'b0;
              scl_d      = 1'b0;
            end
          end
        end
        PH_ST_A: if (wait_over) sda_d = 1'b0;
        PH_ST_B: begin
          if (wait_over) begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        PH_SP_A: if (wait_over) scl_d = 1'b1;
        PH_SP_B: begin
          if (wait_over) begin
            sda_d = 1'b1;
            done  = 1'b1;
          end
        end
        PH_WR_HIGH: begin
          if (wait_over) begin
            scl_d     = 1'b0;
            bit_cnt_d = bit_cnt_q + 1'b1;
          end
        end
        PH_WR_LOW: begin
          if (wait_over) begin
            scl_d = 1'b1;
            sda_d = (bit_cnt_q >= BITS_PER_BYTE) ? 1'b1 : shift_q[wr_idx];
          end
        end
        PH_ACK_HIGH: if (wait_over) ack_cnt_d = '0;
        PH_ACK_LOW:  if (wait_over) done = 1'b1;
        PH_RD_HIGH: begin
          if (wait_over) begin
            shift_d   = {shift_q[BYTE_W-2:0], sda_s};
            bit_cnt_d = bit_cnt_q + 1'b1;
            scl_d     = 1'b0;
          end
        end
        PH_RD_LOW: begin
          if (wait_over) begin
            scl_d = 1'b1;
            if (bit_cnt_q >= BITS_PER_BYTE) begin
              sda_d = 1'b1;
            end
          end
        end
        PH_NACK_HIGH: begin
          if (wait_over) begin
            scl_d     = 1'b0;
            rx_hold_d = shift_q;
            done      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (res_src.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      ack_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      rx_hold_q   <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      ack_cnt_q   <= ack_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      rx_hold_q   <= rx_hold_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_flag_q  <= ack_flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.scl_out   <= scl_d;
      out_q.sda_out   <= sda_d;
      out_q.ready_res <= (phase_d == PH_IDLE);
      out_q.done_res  <= done;
      out_q.rx_byte   <= rx_hold_d;
      out_q.ack_seen  <= ack_flag_d;
    end
  end

  assign res_src.valid   = out_valid_q;
  assign res_src.payload = out_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_src.valid && res_src.payload.done_res |-> res_src.payload.ready_res)
    else $error("completion reported while still busy");
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= BITS_PER_BYTE)
    else $error("bit counter ran past one byte");
  a_ack_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && phase_q == PH_ACK_POLL && !sda_s |=> ack_flag_q && phase_q == PH_ACK_LOW)
    else $error("slave acknowledge not taken");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_src.valid && !res_src.ready |=> res_src.valid && !q_snk.ready == !res_src.ready)
    else $error("stalled result dropped");
`endif

endmodule

FILE: rtl/core/i2c_master_byte_engine.sv
// top level of the i2c master byte engine: config registers, front queue, bit engine
//
//  channel  dir  handshake             payload
//  tick_i   in   tick_i.valid/ready    cmd_valid, mode, tx_byte, sda_in
//  res_o    out  res_o.valid/ready     scl_out, sda_out, ready_res, done_res, rx_byte, ack_seen
//  cfg      in   cfg_we_i (no ready)   cfg_idx_i, cfg_wdata_i
//
//  one tick per clock when neither side stalls; a tick leaves the front queue
//  and its result is registered in the bit engine
//  the two-entry queue and the result register let either side stall on its own
//  reset puts both lines released, the sequencer idle, half_period 250, ack_timeout 0
module i2c_master_byte_engine #(
  parameter int unsigned TimerWidth = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  i2cm_chan_if.sink                     tick_i,
  i2cm_chan_if.source                   res_o,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import i2cm_pkg::*;

  i2cm_cfg_t cfg_q;

  i2cm_chan_if #(.payload_t(i2cm_item_t)) q_if ();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HALF_PERIOD_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata_i;
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_snk (tick_i),
    .q_src    (q_if)
  );

  i2cm_engine #(
    .TimerWidth (TimerWidth)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .q_snk   (q_if),
    .res_src (res_o)
  );

endmodule

FILE: verif/tb_i2c_master_byte_engine.sv
// self-checking testbench for the i2c master byte engine: bus-level predictor and tick stream
module tb_i2c_master_byte_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int NO_ACK      = 1 << 30;
  localparam int SDA_RANDOM  = 2;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  i2cm_chan_if #(.payload_t(i2cm_in_t))  tick_ch ();
  i2cm_chan_if #(.payload_t(i2cm_out_t)) res_ch ();

  i2c_master_byte_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .tick_i      (tick_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor copy of the engine state and its registers
  phase_e             bus_phase  = PH_IDLE;
  logic [BIT_CNT_W-1:0] bits_done = '0;
  logic [BYTE_W-1:0]  shift_q    = '0;
  logic [CFG_W-1:0]   wait_ticks = '0;
  logic [CFG_W-1:0]   poll_ticks = '0;
  logic               scl_q      = 1'b1;
  logic               sda_q      = 1'b1;
  logic               ack_q      = 1'b0;
  logic [BYTE_W-1:0]  rx_q       = '0;
  logic [CFG_W-1:0]   cfg_half   = HALF_PERIOD_RST;
  logic [CFG_W-1:0]   cfg_ack_tmo = ACK_TIMEOUT_RST;

  i2cm_out_t pending_levels[$];
  i2cm_out_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int mismatch_cnt  = 0;
  int ticks_sent    = 0;
  int cycles        = 0;
  int ack_hits      = 0;
  int ack_misses    = 0;
  int n_cmds[4]     = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void move_to(phase_e p);
    bus_phase  = p;
    wait_ticks = CFG_W'(1);
  endfunction

  function automatic logic half_over();
    if (wait_ticks >= cfg_half) return 1'b1;
    wait_ticks++;
    return 1'b0;
  endfunction

  // one tick of the bit engine, returns the line levels and flags it leaves behind
  function automatic i2cm_out_t next_bus_levels(i2cm_in_t t);
    i2cm_out_t r;
    logic fin;
    fin = 1'b0;
    case (bus_phase)
      PH_IDLE: begin
        if (t.cmd_valid) begin
          bits_done = '0;
          case (mode_e'(t.mode))
            MODE_START: begin
              scl_q = 1'b1; sda_q = 1'b1; move_to(PH_ST_A);
            end
            MODE_STOP: begin
              scl_q = 1'b0; sda_q = 1'b0; move_to(PH_SP_A);
            end
            MODE_WRITE: begin
              shift_q = t.tx_byte; sda_q = t.tx_byte[7]; scl_q = 1'b1;
              move_to(PH_WR_HIGH);
            end
            default: begin
              shift_q = '0; sda_q = 1'b1; scl_q = 1'b1; move_to(PH_RD_HIGH);
            end
          endcase
        end
      end
      PH_ACK_POLL: begin
        if (!t.sda_in) begin
          ack_q = 1'b1; scl_q = 1'b0; move_to(PH_ACK_LOW);
          ack_hits++;
        end else begin
          if (poll_ticks != '1) poll_ticks++;
          if (cfg_ack_tmo != 0 && poll_ticks >= cfg_ack_tmo) begin
            ack_q = 1'b0; scl_q = 1'b0; move_to(PH_ACK_LOW);
            ack_misses++;
          end
        end
      end
      default: begin
        if (half_over()) begin
          case (bus_phase)
            PH_ST_A: begin
              sda_q = 1'b0; move_to(PH_ST_B);
            end
            PH_ST_B: begin
              scl_q = 1'b0; bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_SP_A: begin
              scl_q = 1'b1; move_to(PH_SP_B);
            end
            PH_SP_B: begin
              sda_q = 1'b1; bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_WR_HIGH: begin
              scl_q = 1'b0; bits_done++; move_to(PH_WR_LOW);
            end
            PH_WR_LOW: begin
              if (bits_done >= BITS_PER_BYTE) begin
                sda_q = 1'b1; scl_q = 1'b1; move_to(PH_ACK_HIGH);
              end else begin
                sda_q = shift_q[7 - bits_done]; scl_q = 1'b1; move_to(PH_WR_HIGH);
              end
            end
            PH_ACK_HIGH: begin
              bus_phase = PH_ACK_POLL; poll_ticks = '0;
            end
            PH_ACK_LOW: begin
              bus_phase = PH_IDLE; fin = 1'b1;
            end
            PH_RD_HIGH: begin
              // sample at the end of the high half
              shift_q = {shift_q[BYTE_W-2:0], t.sda_in};
              bits_done++; scl_q = 1'b0; move_to(PH_RD_LOW);
            end
            PH_RD_LOW: begin
              if (bits_done >= BITS_PER_BYTE) begin
                sda_q = 1'b1; scl_q = 1'b1; move_to(PH_NACK_HIGH);
              end else begin
                scl_q = 1'b1; move_to(PH_RD_HIGH);
              end
            end
            PH_NACK_HIGH: begin
              scl_q = 1'b0; rx_q = shift_q; bus_phase = PH_IDLE; fin = 1'b1;
            end
            default: bus_phase = PH_IDLE;
          endcase
        end
      end
    endcase
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.ready_res = (bus_phase == PH_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.ack_seen  = ack_q;
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: result with nothing outstanding, got %0h", $time, res_ch.payload);
        mismatch_cnt++;
      end else begin
        want = pending_levels.pop_front();
        check_field("scl_out", want.scl_out, res_ch.payload.scl_out);
        check_field("sda_out", want.sda_out, res_ch.payload.sda_out);
        check_field("ready_res", want.ready_res, res_ch.payload.ready_res);
        check_field("done_res", want.done_res, res_ch.payload.done_res);
        check_field("rx_byte", want.rx_byte, res_ch.payload.rx_byte);
        check_field("ack_seen", want.ack_seen, res_ch.payload.ack_seen);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles", $time, cycles);
      $display("i2c_master_byte_engine verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off counted here
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input i2cm_in_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.payload <= t;
    do @(posedge clk); while (!tick_ch.ready);
    pending_levels.push_back(next_bus_levels(t));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    if (tick_ch.valid) tick_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  // only called with every result back, though a command may still be under way
  task automatic set_config(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HALF_PERIOD;
    cfg_wdata <= half;
    @(negedge clk);
    cfg_idx   <= CFG_ACK_TIMEOUT;
    cfg_wdata <= tmo;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_half    = half;
    cfg_ack_tmo = tmo;
    @(negedge clk);
  endtask

  // first tick of a command
  task automatic issue_cmd(input mode_e m, input logic [BYTE_W-1:0] b, input int sda_level);
    i2cm_in_t t;
    t.cmd_valid = 1'b1;
    t.mode      = m;
    t.tx_byte   = b;
    t.sda_in    = (sda_level < SDA_RANDOM) ? sda_level[0] : 1'($urandom_range(1));
    send_tick(t);
  endtask

  // one tick while a command is under way; commands offered now must be dropped
  task automatic busy_tick(input int ack_after, input int sda_level);
    i2cm_in_t t;
    t.cmd_valid = ($urandom_range(99) < 15);
    t.mode      = 2'($urandom_range(3));
    t.tx_byte   = 8'($urandom_range(255));
    if (bus_phase == PH_ACK_POLL) t.sda_in = (int'(poll_ticks) >= ack_after) ? 1'b0 : 1'b1;
    else if (sda_level < SDA_RANDOM) t.sda_in = sda_level[0];
    else t.sda_in = 1'($urandom_range(1));
    send_tick(t);
  endtask

  // issue one command and keep ticking until the engine is idle again
  task automatic run_cmd(input mode_e m, input logic [BYTE_W-1:0] b, input int ack_after,
                         input int sda_level);
    issue_cmd(m, b, sda_level);
    while (bus_phase != PH_IDLE) busy_tick(ack_after, sda_level);
    n_cmds[m]++;
  endtask

  // start a command, pause it after a few ticks, then finish it under new settings
  task automatic run_cmd_reconfig(input mode_e m, input logic [BYTE_W-1:0] b,
                                  input int ack_after, input int n_ticks,
                                  input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] tmo);
    issue_cmd(m, b, SDA_RANDOM);
    repeat (n_ticks) begin
      if (bus_phase != PH_IDLE) busy_tick(ack_after, SDA_RANDOM);
    end
    drain();
    set_config(half, tmo);
    while (bus_phase != PH_IDLE) busy_tick(ack_after, SDA_RANDOM);
    n_cmds[m]++;
  endtask

  task automatic quiet_tick();
    i2cm_in_t t;
    t.cmd_valid = 1'b0;
    t.mode      = 2'($urandom_range(3));
    t.tx_byte   = 8'($urandom_range(255));
    t.sda_in    = 1'($urandom_range(1));
    send_tick(t);
  endtask

  function automatic int random_ack_after();
    if (cfg_ack_tmo == 0) return $urandom_range(0, 6);
    return $urandom_range(0, cfg_ack_tmo + 2);
  endfunction

  task automatic random_transfer();
    int nbytes;
    nbytes = $urandom_range(1, 3);
    run_cmd(MODE_START, 8'($urandom_range(255)), 0, SDA_RANDOM);
    repeat (nbytes) begin
      if ($urandom_range(1)) begin
        run_cmd(MODE_WRITE, 8'($urandom_range(255)), random_ack_after(), SDA_RANDOM);
      end else begin
        run_cmd(MODE_READ, 8'($urandom_range(255)), 0, SDA_RANDOM);
      end
    end
    run_cmd(MODE_STOP, 8'($urandom_range(255)), 0, SDA_RANDOM);
  endtask

  task automatic test_reset_values();
    quiet_tick();
    // start at the reset half period, then finish it quickly well into the first wait
    run_cmd_reconfig(MODE_START, 8'h00, 0, 40, 16'd1, 16'd0);
    run_cmd(MODE_STOP, 8'hFF, 0, SDA_RANDOM);
    drain();
  endtask

  task automatic test_directed();
    set_config(16'd1, 16'd0);
    run_cmd(MODE_START, 8'h00, 0, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'hFF, 0, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'h00, 12, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'h80, 1, SDA_RANDOM);
    run_cmd(MODE_READ, 8'h00, 0, 0);
    run_cmd(MODE_READ, 8'h00, 0, 1);
    run_cmd(MODE_READ, 8'hA5, 0, SDA_RANDOM);
    quiet_tick();
    run_cmd(MODE_STOP, 8'h00, 0, SDA_RANDOM);
    drain();
    // finite ack timeout: miss, ack just before the limit, ack never in time
    set_config(16'd3, 16'd4);
    run_cmd(MODE_START, 8'h00, 0, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'h01, NO_ACK, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'h5A, 3, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'h7F, 4, SDA_RANDOM);
    run_cmd(MODE_READ, 8'h00, 0, SDA_RANDOM);
    run_cmd(MODE_STOP, 8'h00, 0, SDA_RANDOM);
    drain();
  endtask

  task automatic test_register_extremes();
    set_config(16'hFFFF, 16'd0);
    run_cmd_reconfig(MODE_START, 8'h00, 0, 8, 16'd1, 16'hFFFF);
    // longest ack timeout, cut short by a lower limit once polling is under way
    run_cmd_reconfig(MODE_WRITE, 8'($urandom_range(255)), NO_ACK, 30, 16'd1, 16'd1);
    run_cmd(MODE_WRITE, 8'($urandom_range(255)), NO_ACK, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'($urandom_range(255)), 0, SDA_RANDOM);
    run_cmd(MODE_STOP, 8'h00, 0, SDA_RANDOM);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'd2, 16'd0);
    // results held back while requests keep coming, so the input side stalls
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    run_cmd(MODE_START, 8'h00, 0, SDA_RANDOM);
    run_cmd(MODE_WRITE, 8'($urandom_range(255)), 2, SDA_RANDOM);
    run_cmd(MODE_READ, 8'h00, 0, SDA_RANDOM);
    run_cmd(MODE_STOP, 8'h00, 0, SDA_RANDOM);
    drain();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int n_ticks);
    int first;
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = ticks_sent;
    while (ticks_sent - first < n_ticks) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        drain();
        set_config(($urandom_range(9) < 7) ? 16'($urandom_range(1, 2)) :
                                             16'($urandom_range(3, 6)),
                   ($urandom_range(9) < 3) ? 16'd0 : 16'($urandom_range(1, 5)));
      end else if (pick < 10) begin
        drain();
      end else if (pick < 18) begin
        quiet_tick();
      end else if (pick < 70) begin
        random_transfer();
      end else begin
        run_cmd(mode_e'($urandom_range(3)), 8'($urandom_range(255)), random_ack_after(),
                SDA_RANDOM);
      end
    end
    drain();
  endtask

  initial begin
    tick_ch.valid   = 1'b0;
    tick_ch.payload = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(27, 51, 30);
    test_random(51, 27, 30);
    test_random(0, 0, 30);

    drain();
    repeat (10) @(negedge clk);
    $display("ran %0d bus ticks: %0d start, %0d stop, %0d write, %0d read commands",
             ticks_sent, n_cmds[MODE_START], n_cmds[MODE_STOP], n_cmds[MODE_WRITE],
             n_cmds[MODE_READ]);
    $display("slave acknowledged %0d writes, %0d ended on ack timeout; %0d mismatches",
             ack_hits, ack_misses, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("i2c_master_byte_engine verification clean");
    end else begin
      $display("i2c_master_byte_engine verification failed");
    end
    $finish;
  end

endmodule
